FILE: rtl/tfir_pkg.sv
// Shared types, widths and codes for the timed FIR filter.
package tfir_pkg;

	localparam int MAX_TAPS_DEF = 16;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 16;
	localparam int TICK_W   = 32;
	localparam int TAPCNT_W = 5;
	localparam int CIDX_W   = 4;
	localparam int GAIN_W   = 16;
	localparam int PERIOD_W = 16;

	// Accumulator holds up to 31 terms of at most 18 bits each.
	localparam int ACC_W  = 24;
	localparam int PROD_W = ACC_W + GAIN_W;

	// Coefficients are Q2.14, gain is Q8.8.
	localparam int COEFF_FRAC = 14;
	localparam int GAIN_FRAC  = 8;

	localparam logic signed [PROD_W-1:0] SAT_HI = 32767;
	localparam logic signed [PROD_W-1:0] SAT_LO = -32768;

	// Configuration port.
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 4;
	localparam int REGIDX_W   = PADDR_W - 2;

	localparam logic [REGIDX_W-1:0] REG_TAP_COUNT     = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_GAIN          = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

	localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST     = 5'd16;
	localparam logic [GAIN_W-1:0]   GAIN_RST          = 16'd256;
	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd0;

	// Transaction kinds.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_COEFF  = 1'b1;

	typedef struct packed {
		logic                       action;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [TICK_W-1:0]          now_tick;
		logic [CIDX_W-1:0]          coeff_index;
		logic signed [COEFF_W-1:0]  coeff_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered_out;
		logic                       took_sample;
		logic                       saturated;
	} out_item_t;

	typedef struct packed {
		logic [TAPCNT_W-1:0]      tap_count;
		logic signed [GAIN_W-1:0] gain;
		logic [PERIOD_W-1:0]      sample_period;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic gain_go;
	} mac_ctrl_t;

	typedef struct packed {
		logic                       busy;
		logic                       done;
		logic                       sat;
		logic signed [SAMPLE_W-1:0] result;
	} mac_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_TAPS,
		ST_DRAIN,
		ST_GAIN,
		ST_SCALE,
		ST_OUT
	} fsm_t;

endpackage

FILE: rtl/tfir_regs.sv
// Configuration register bank behind the APB-style port.
module tfir_regs
	import tfir_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t                cfg_q;
	logic [REGIDX_W-1:0] idx;
	logic                wr;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_count     <= TAP_COUNT_RST;
			cfg_q.gain          <= GAIN_RST;
			cfg_q.sample_period <= SAMPLE_PERIOD_RST;
		end else if (wr) begin
			case (idx)
				REG_TAP_COUNT:     cfg_q.tap_count     <= pwdata[TAPCNT_W-1:0];
				REG_GAIN:          cfg_q.gain          <= pwdata[GAIN_W-1:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TAP_COUNT:     prdata = DATA_W'(cfg_q.tap_count);
			REG_GAIN:          prdata = DATA_W'(cfg_q.gain);
			REG_SAMPLE_PERIOD: prdata = DATA_W'(cfg_q.sample_period);
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: rtl/tfir_store.sv
// Single-port-write, single-port-read store with per-entry valid bits; unwritten entries read zero.
module tfir_store #(
	parameter int DEPTH = 16,
	parameter int W     = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0]     rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tfir_mac.sv
// Shared multiplier with tap accumulator and the final gain, rounding and clipping step.
module tfir_mac
	import tfir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctrl_t                  ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [COEFF_W-1:0]  coeff,
	input  logic signed [GAIN_W-1:0]   gain,
	output mac_sts_t                   sts
);

	logic                       vld_s1;
	logic                       vld_s2;
	logic                       gvld_s2;
	logic                       done_q;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       sat_q;

	logic signed [ACC_W-1:0]    mul_a;
	logic signed [GAIN_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [PROD_W-1:0]   tap_rnd;
	logic signed [PROD_W-1:0]   tap_term;
	logic signed [PROD_W-1:0]   g_rnd;
	logic signed [PROD_W-1:0]   g_sh;

	// One multiplier serves both the taps and the gain.
	assign mul_a = ctrl.gain_go ? acc_q : ACC_W'(sample);
	assign mul_b = ctrl.gain_go ? gain : coeff;
	assign mul_p = mul_a * mul_b;

	// Division by a power of two that truncates toward zero.
	assign tap_rnd  = prod_s2 + (prod_s2[PROD_W-1] ? PROD_W'((1 << COEFF_FRAC) - 1) : '0);
	assign tap_term = tap_rnd >>> COEFF_FRAC;
	assign g_rnd    = prod_s2 + (prod_s2[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : '0);
	assign g_sh     = g_rnd >>> GAIN_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			gvld_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= ctrl.issue;
			vld_s2  <= vld_s1;
			gvld_s2 <= ctrl.gain_go;
			done_q  <= gvld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 || ctrl.gain_go) begin
			prod_s2 <= mul_p;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + signed'(tap_term[ACC_W-1:0]);
		end
		if (gvld_s2) begin
			if (g_sh > SAT_HI) begin
				res_q <= SAT_HI[SAMPLE_W-1:0];
				sat_q <= 1'b1;
			end else if (g_sh < SAT_LO) begin
				res_q <= SAT_LO[SAMPLE_W-1:0];
				sat_q <= 1'b1;
			end else begin
				res_q <= g_sh[SAMPLE_W-1:0];
				sat_q <= 1'b0;
			end
		end
	end

	assign sts.busy   = vld_s1 || vld_s2;
	assign sts.done   = done_q;
	assign sts.sat    = sat_q;
	assign sts.result = res_q;

endmodule

FILE: rtl/tfir_seq.sv
// Sequencer: time gate, delay-line pointer, tap walk and the output register.
module tfir_seq
	import tfir_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	parameter int AW       = $clog2(MAX_TAPS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_item,
	input  cfg_t                      cfg,
	output mac_ctrl_t                 mac_ctrl,
	input  mac_sts_t                  mac_sts,
	output logic                      dl_we,
	output logic [AW-1:0]             dl_waddr,
	output logic [SAMPLE_W-1:0]       dl_wdata,
	output logic [AW-1:0]             dl_raddr,
	output logic                      cf_we,
	output logic [AW-1:0]             cf_waddr,
	output logic [COEFF_W-1:0]        cf_wdata,
	output logic [AW-1:0]             cf_raddr,
	output fsm_t                      state
);

	localparam int NMAX = (MAX_TAPS < 31) ? MAX_TAPS : 31;
	localparam int CW   = (AW > TAPCNT_W) ? AW : TAPCNT_W;

	fsm_t                state_q;
	fsm_t                state_nxt;
	in_item_t            item_q;
	logic [AW-1:0]       ptr_q;
	logic [TICK_W-1:0]   last_tick_q;
	logic [SAMPLE_W-1:0] held_q;
	logic                took_q;
	logic [AW-1:0]       k_q;
	logic [AW-1:0]       pos_q;
	logic [TAPCNT_W-1:0] rem_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [TAPCNT_W-1:0] n_taps;
	logic [AW-1:0]       last_idx;
	logic [AW-1:0]       p_eff;
	logic [TICK_W-1:0]   elapsed;
	logic                is_coeff;
	logic                take;
	logic                idx_ok;
	logic                out_load;

	always_comb begin
		if (cfg.tap_count == '0) begin
			n_taps = TAPCNT_W'(1);
		end else if (cfg.tap_count > TAPCNT_W'(NMAX)) begin
			n_taps = TAPCNT_W'(NMAX);
		end else begin
			n_taps = cfg.tap_count;
		end
	end

	assign last_idx = AW'(n_taps - TAPCNT_W'(1));
	assign p_eff    = (CW'(ptr_q) >= CW'(n_taps)) ? '0 : ptr_q;
	assign elapsed  = item_q.now_tick - last_tick_q;
	assign is_coeff = item_q.action == ACT_COEFF;
	assign take     = !is_coeff && (elapsed > TICK_W'(cfg.sample_period));
	assign idx_ok   = 32'(item_q.coeff_index) < MAX_TAPS;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = take ? ST_TAPS : ST_OUT;
			ST_TAPS:   if (rem_q == TAPCNT_W'(1)) state_nxt = ST_DRAIN;
			ST_DRAIN:  if (!mac_sts.busy) state_nxt = ST_GAIN;
			ST_GAIN:   state_nxt = ST_SCALE;
			ST_SCALE:  if (mac_sts.done) state_nxt = ST_OUT;
			ST_OUT:    if (out_load) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall         = state_q != ST_IDLE;
		dl_we            = (state_q == ST_DECIDE) && take;
		cf_we            = (state_q == ST_DECIDE) && is_coeff && idx_ok;
		mac_ctrl.clear   = state_q == ST_DECIDE;
		mac_ctrl.issue   = state_q == ST_TAPS;
		mac_ctrl.gain_go = state_q == ST_GAIN;
	end

	assign dl_waddr = p_eff;
	assign dl_wdata = item_q.sample_in;
	assign dl_raddr = pos_q;
	assign cf_waddr = AW'(item_q.coeff_index);
	assign cf_wdata = item_q.coeff_value;
	assign cf_raddr = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			last_tick_q <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dl_we) begin
				ptr_q       <= (p_eff == last_idx) ? '0 : p_eff + AW'(1);
				last_tick_q <= item_q.now_tick;
			end
			if ((state_q == ST_SCALE) && mac_sts.done) begin
				held_q <= mac_sts.result;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == ST_DECIDE) begin
			took_q <= take;
			k_q    <= '0;
			pos_q  <= p_eff;
			rem_q  <= n_taps;
		end
		if (state_q == ST_TAPS) begin
			k_q   <= k_q + AW'(1);
			pos_q <= (pos_q == '0) ? last_idx : pos_q - AW'(1);
			rem_q <= rem_q - TAPCNT_W'(1);
		end
		if (out_load) begin
			out_item_q.filtered_out <= held_q;
			out_item_q.took_sample  <= took_q;
			out_item_q.saturated    <= took_q && mac_sts.sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign state     = state_q;

endmodule

FILE: rtl/timed_fir_filter.sv
// Top level of the time-gated FIR filter.
//
// Each input transaction either writes one Q2.14 coefficient or offers a signed 16-bit
// sample stamped with a free-running 32-bit tick. A sample is taken only when the ticks
// elapsed since the last taken sample (modulo 2^32) strictly exceed sample_period; it is
// then written into a circular delay line of tap_count entries, clamped to 1..MAX_TAPS,
// and the output is formed as the convolution of the coefficients with the newest
// samples, each product truncated toward zero, scaled by the Q8.8 gain, truncated and
// clipped to 16 bits. Every input transaction yields exactly one output transaction;
// coefficient writes and rejected samples return the previous filtered value with both
// flags clear. The filter is built around a single shared multiplier walked by a
// sequencer, so the block handles one transaction at a time and holds in_stall high
// while it works. A filtered sample passes the decide, taps, drain, gain and scale
// states before it reaches the output register: one multiply per tap through the
// registered delay-line and coefficient reads, a drain of the multiplier pipeline and
// the gain pass. A coefficient write or a rejected sample goes from the decide state
// straight to the output register. Once that register is loaded the sequencer returns
// to idle, where the next transaction can be accepted. The output register lets a
// finished result wait for the consumer while the next input transaction is accepted.
// Registers sit at byte addresses 0 (tap_count), 4 (gain) and 8 (sample_period) and
// must only be written while the block is idle. The delay line and coefficients start
// at zero after reset with no clearing pass, as each entry carries its own valid bit.
module timed_fir_filter
	import tfir_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_TAPS);

	cfg_t                cfg;
	mac_ctrl_t           mac_ctrl;
	mac_sts_t            mac_sts;
	fsm_t                state;

	logic                dl_we;
	logic [AW-1:0]       dl_waddr;
	logic [SAMPLE_W-1:0] dl_wdata;
	logic [AW-1:0]       dl_raddr;
	logic [SAMPLE_W-1:0] dl_rdata;
	logic                cf_we;
	logic [AW-1:0]       cf_waddr;
	logic [COEFF_W-1:0]  cf_wdata;
	logic [AW-1:0]       cf_raddr;
	logic [COEFF_W-1:0]  cf_rdata;

	// Configuration registers.
	tfir_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer owns the time gate, the write pointer and the held output.
	tfir_seq #(
		.MAX_TAPS (MAX_TAPS),
		.AW       (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg       (cfg),
		.mac_ctrl  (mac_ctrl),
		.mac_sts   (mac_sts),
		.dl_we     (dl_we),
		.dl_waddr  (dl_waddr),
		.dl_wdata  (dl_wdata),
		.dl_raddr  (dl_raddr),
		.cf_we     (cf_we),
		.cf_waddr  (cf_waddr),
		.cf_wdata  (cf_wdata),
		.cf_raddr  (cf_raddr),
		.state     (state)
	);

	// Delay line of past samples.
	tfir_store #(
		.DEPTH (MAX_TAPS),
		.W     (SAMPLE_W),
		.AW    (AW)
	) u_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dl_we),
		.waddr  (dl_waddr),
		.wdata  (dl_wdata),
		.raddr  (dl_raddr),
		.rdata  (dl_rdata)
	);

	// Tap coefficients.
	tfir_store #(
		.DEPTH (MAX_TAPS),
		.W     (COEFF_W),
		.AW    (AW)
	) u_coeff (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cf_we),
		.waddr  (cf_waddr),
		.wdata  (cf_wdata),
		.raddr  (cf_raddr),
		.rdata  (cf_rdata)
	);

	// The shared multiply-accumulate unit sees the registered memory outputs directly.
	tfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (signed'(dl_rdata)),
		.coeff  (signed'(cf_rdata)),
		.gain   (cfg.gain),
		.sts    (mac_sts)
	);

	// The multiplier pipeline only carries work while the taps are walked or drained.
	a_mac_busy_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mac_sts.busy |-> (state == ST_TAPS || state == ST_DRAIN))
		else $error("multiplier pipeline active outside the tap walk");

	// A finished gain pass is only ever seen while the sequencer waits for it.
	a_done_in_scale: assert property (@(posedge clk) disable iff (!arst_n)
		mac_sts.done |-> state == ST_SCALE)
		else $error("gain result arrived outside the scale step");

	// Clipping can only be reported on a transaction whose sample was filtered.
	a_sat_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.saturated |-> out_item.took_sample)
		else $error("saturation flagged without a taken sample");

	// Once a transaction is taken the block stops accepting until it has finished.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while one is in flight");

endmodule

FILE: bench/tb_timed_fir_filter.sv
// Self-checking testbench for the time-gated FIR filter: random traffic, own predictor.
`timescale 1ns / 1ps

module tb_timed_fir_filter;
	import tfir_pkg::*;

	// Idle cycles with no transaction on either channel and no register
	// access before the run is declared hung. The longest legitimate quiet
	// spell is the deliberate output hold-off plus one filter pass.
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_OFF_LEN  = 400;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_ITEMS   = 217;
	localparam int TAIL_CYCLES   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	timed_fir_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the filter's registers and memories.
	// ------------------------------------------------------------------
	logic [TAPCNT_W-1:0]        tap_cfg = TAP_COUNT_RST;
	logic signed [GAIN_W-1:0]   gain_cfg = GAIN_RST;
	logic [PERIOD_W-1:0]        period_cfg = SAMPLE_PERIOD_RST;

	logic signed [SAMPLE_W-1:0] history [MAX_TAPS_DEF];
	logic signed [COEFF_W-1:0]  coeff_mem [MAX_TAPS_DEF];
	int                         wr_ptr = 0;
	logic [TICK_W-1:0]          last_tick = '0;
	logic signed [SAMPLE_W-1:0] held_value = '0;

	in_item_t  pending_items [$];
	out_item_t expected_outputs [$];

	int mismatch_count = 0;
	int results_checked = 0;
	int samples_taken = 0;
	int samples_rejected = 0;
	int coeff_loads = 0;
	int clipped_outputs = 0;
	int settings_used = 0;
	bit steady_feed = 1'b0;

	initial begin
		for (int j = 0; j < MAX_TAPS_DEF; j++) begin
			history[j] = '0;
			coeff_mem[j] = '0;
		end
	end

	// Works out the result of one accepted input transaction and advances the
	// predictor state. A sample passes the tick gate only when the wrapped
	// 32-bit distance from the last taken tick is strictly above the period.
	function automatic out_item_t filter_step(input in_item_t it);
		out_item_t  r;
		logic [TICK_W-1:0] elapsed;
		int         n;
		int         p;
		int         pos;
		longint     acc;
		longint     scaled;
		r = '0;
		if (it.action == ACT_COEFF) begin
			coeff_mem[it.coeff_index] = it.coeff_value;
			coeff_loads++;
		end else begin
			elapsed = it.now_tick - last_tick;
			if (elapsed > TICK_W'(period_cfg)) begin
				// Out-of-range tap counts are clamped to 1..MAX_TAPS.
				n = int'(tap_cfg);
				if (n < 1) n = 1;
				if (n > MAX_TAPS_DEF) n = MAX_TAPS_DEF;
				// A pointer left beyond a freshly shortened line restarts at slot 0.
				p = wr_ptr;
				if (p >= n) p = 0;
				last_tick = it.now_tick;
				history[p] = it.sample_in;
				acc = 0;
				for (int k = 0; k < n; k++) begin
					pos = (p + n - k) % n;
					acc += (longint'(coeff_mem[k]) * longint'(history[pos]))
						/ (longint'(1) << COEFF_FRAC);
				end
				wr_ptr = (p + 1) % n;
				scaled = (acc * longint'(gain_cfg)) / (longint'(1) << GAIN_FRAC);
				if (scaled > 32767) begin
					scaled = 32767;
					r.saturated = 1'b1;
				end else if (scaled < -32768) begin
					scaled = -32768;
					r.saturated = 1'b1;
				end
				held_value = 16'(scaled);
				r.took_sample = 1'b1;
				samples_taken++;
				if (r.saturated) clipped_outputs++;
			end else begin
				samples_rejected++;
			end
		end
		r.filtered_out = held_value;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input driver: offers queued transactions in bursts of random length
	// separated by random gaps. The prediction is made at the edge where a
	// transaction is accepted, so it sees the items in the block's own order.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_outputs.push_back(filter_step(in_item));
			// A new payload may only be presented once the current one is gone.
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_valid <= 1'b1;
					in_item <= pending_items.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = steady_feed ? 0 : $urandom_range(0, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor and stall generator. The stall pattern switches between
	// never stalling, light and heavy random stalls, and a strict toggle, each
	// for a random number of cycles. Once, mid-run, it holds off for a long
	// stretch so that the block's output register fills and its input backs up.
	// ------------------------------------------------------------------
	int   stall_mode = 0;
	int   stall_phase_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	out_item_t wanted;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = 0;
			stall_phase_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_outputs.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result %0d: out=%0d took=%0b sat=%0b",
							results_checked, out_item.filtered_out,
							out_item.took_sample, out_item.saturated);
				end else begin
					wanted = expected_outputs.pop_front();
					if (out_item.filtered_out !== wanted.filtered_out ||
							out_item.took_sample !== wanted.took_sample ||
							out_item.saturated !== wanted.saturated) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("mismatch on result %0d: expected out=%0d took=%0b sat=%0b",
								results_checked, wanted.filtered_out,
								wanted.took_sample, wanted.saturated);
							$display("  got out=%0d took=%0b sat=%0b",
								out_item.filtered_out, out_item.took_sample,
								out_item.saturated);
						end
					end
				end
			end

			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_checked >= 600) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_LEN;
				out_stall <= 1'b1;
			end else begin
				if (stall_phase_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_phase_left = $urandom_range(20, 150);
				end else begin
					stall_phase_left--;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a run that stops moving is a failure.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results pending",
					quiet_cycles, expected_outputs.size());
				$display("FAIL timed_fir_filter");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. Fields that an item's action ignores are still
	// randomised so that every payload bit toggles.
	// ------------------------------------------------------------------
	function automatic void push_sample(input logic signed [SAMPLE_W-1:0] s,
			input logic [TICK_W-1:0] t);
		in_item_t it;
		it.action = ACT_SAMPLE;
		it.sample_in = s;
		it.now_tick = t;
		it.coeff_index = CIDX_W'($urandom);
		it.coeff_value = COEFF_W'($urandom);
		pending_items.push_back(it);
	endfunction

	function automatic void push_coeff(input logic [CIDX_W-1:0] idx,
			input logic signed [COEFF_W-1:0] v);
		in_item_t it;
		it.action = ACT_COEFF;
		it.sample_in = SAMPLE_W'($urandom);
		it.now_tick = $urandom;
		it.coeff_index = idx;
		it.coeff_value = v;
		pending_items.push_back(it);
	endfunction

	// Waits until every queued transaction has gone in and every result is out.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write followed by a read-back of the same register.
	task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] seen;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TAP_COUNT: tap_cfg = value[TAPCNT_W-1:0];
			REG_GAIN: gain_cfg = value[GAIN_W-1:0];
			REG_SAMPLE_PERIOD: period_cfg = value[PERIOD_W-1:0];
			default: ;
		endcase
		mask = (idx == REG_TAP_COUNT) ? DATA_W'((1 << TAPCNT_W) - 1) : DATA_W'(16'hFFFF);

		@(posedge clk);
		psel <= 1'b1;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		seen = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if ((seen & mask) !== (value & mask)) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("register %0d read back 0x%0h, expected 0x%0h",
					idx, seen & mask, value & mask);
		end
	endtask

	task automatic set_config(input logic [TAPCNT_W-1:0] taps,
			input logic signed [GAIN_W-1:0] g, input logic [PERIOD_W-1:0] per);
		write_reg(REG_TAP_COUNT, DATA_W'(taps));
		write_reg(REG_GAIN, {16'h0, g});
		write_reg(REG_SAMPLE_PERIOD, DATA_W'(per));
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		logic [TICK_W-1:0]          tick_now;
		logic [TAPCNT_W-1:0]        taps;
		logic signed [GAIN_W-1:0]   g;
		logic [PERIOD_W-1:0]        per;
		logic signed [SAMPLE_W-1:0] s;
		logic signed [COEFF_W-1:0]  cv;
		int                         sel;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: sixteen taps, unity gain, period zero. The first
		// sample carries the reset tick, so nothing has elapsed and it is
		// turned away.
		settings_used++;
		push_sample(16'sd100, 32'd0);
		push_coeff(4'd0, 16'sd16384);
		push_coeff(4'd1, -16'sd32768);
		push_coeff(4'd15, 16'sd32767);
		push_sample(16'sd32767, 32'd1);
		push_sample(-16'sd32768, 32'd2);
		push_sample(16'sd12345, 32'd3);
		push_sample(-16'sd1, 32'hFFFF_FFFF);
		drain();

		// Tap count zero behaves as a single tap and leaves the write pointer
		// beyond the line. Widest period with the most negative gain: the first
		// sample lands exactly on the period and is refused, the next one
		// crosses the tick wrap, is taken and clips.
		set_config(5'd0, -16'sd32768, 16'hFFFF);
		push_sample(16'sd32767, 32'd65534);
		push_sample(-16'sd32768, 32'd65535);
		push_coeff(4'd0, -16'sd32768);
		drain();

		// A tap count above the maximum is clamped; full positive gain.
		set_config(5'd31, 16'sd32767, 16'd1);
		push_sample(16'sd20000, 32'd65536);
		push_sample(-16'sd20000, 32'd65537);
		push_sample(16'sd32767, 32'd65540);
		drain();

		// Short line at unity gain with a negative coefficient written between samples.
		set_config(5'd3, 16'sd256, 16'd0);
		push_sample(16'sd7, 32'd65541);
		push_sample(-16'sd7, 32'd65542);
		push_coeff(4'd2, -16'sd16384);
		push_sample(16'sd1000, 32'd65543);
		drain();

		// Random phases, each under a fresh register setting. Most samples are
		// spaced just past the period so they are taken; the rest fall inside
		// it, sit right on the boundary, or jump to an arbitrary tick.
		tick_now = 32'd70000;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: taps = TAPCNT_W'($urandom_range(1, 16));
				1: taps = 5'd16;
				2: taps = 5'd1;
				3: taps = 5'd0;
				4: taps = TAPCNT_W'($urandom_range(17, 31));
				default: taps = TAPCNT_W'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 4))
				0: g = 16'sd256;
				1: g = -16'sd256;
				2: g = GAIN_W'($urandom);
				3: g = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
				default: g = GAIN_W'($urandom_range(0, 512) - 256);
			endcase
			case ($urandom_range(0, 3))
				0: per = 16'd0;
				1: per = PERIOD_W'($urandom_range(1, 100));
				2: per = 16'hFFFF;
				default: per = PERIOD_W'($urandom);
			endcase
			set_config(taps, g, per);
			// One phase starts just short of the tick wrap.
			if (ph == 4)
				tick_now = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 200000));
			steady_feed = (ph == 2);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 12) begin
					cv = $urandom_range(0, 1) ? COEFF_W'($urandom)
						: COEFF_W'($urandom_range(0, 8191) - 4096);
					push_coeff(CIDX_W'($urandom), cv);
				end else begin
					s = $urandom_range(0, 1) ? SAMPLE_W'($urandom)
						: SAMPLE_W'($urandom_range(0, 2047) - 1024);
					sel = $urandom_range(0, 99);
					if (sel < 60)
						tick_now = tick_now + per + 1 + $urandom_range(0, 20);
					else if (sel < 75)
						tick_now = tick_now + $urandom_range(0, per);
					else if (sel < 85)
						tick_now = tick_now + per;
					else if (sel < 92)
						tick_now = tick_now + per + 1;
					else
						tick_now = $urandom;
					push_sample(s, tick_now);
				end
			end
			drain();
		end
		steady_feed = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_outputs.size() != 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", expected_outputs.size());
		end

		$display("Covered %0d transactions: %0d filtered, %0d gated out, %0d coefficient loads.",
			results_checked, samples_taken, samples_rejected, coeff_loads);
		$display("%0d register settings used, %0d outputs clipped, %0d mismatches.",
			settings_used, clipped_outputs, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS timed_fir_filter");
		end else begin
			$display("FAIL timed_fir_filter");
		end
		$finish;
	end

endmodule
